>>> rtl/core/phter_pkg.sv
// ----------------------------------------------------------------------------
// phter_pkg: shared types and constants of the point health tracker
// Defaults, controller states and the command/status bundle.
// ----------------------------------------------------------------------------
package phter_pkg;

   localparam int POINT_SLOTS_DEF = 16;
   localparam int RING_DEPTH_DEF  = 64;

   localparam logic [1:0] KIND_THRESHOLD = 2'd2;

   localparam logic [1:0] REASON_ONLINE    = 2'd0;
   localparam logic [1:0] REASON_OFFLINE   = 2'd1;
   localparam logic [1:0] REASON_THR_RAISE = 2'd2;
   localparam logic [1:0] REASON_THR_CLEAR = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_EMIT0,
      ST_EMIT1
   } state_type;

   typedef struct packed {
      logic load;     // capture the sample
      logic search;   // examine one table entry
      logic update;   // write back entry, compute events
      logic emit0;    // present first event
      logic emit1;    // present second event
   } cmd_type;

   typedef struct packed {
      logic key_zero;
      logic search_done;
      logic found;      // hit or free entry available
      logic [1:0] n_events;
   } status_type;

endpackage

>>> rtl/core/phter_ctrl.sv
// ----------------------------------------------------------------------------
// phter_ctrl: sequencer of the point health tracker
// Steps through load, table search, update and event output.
// ----------------------------------------------------------------------------
module phter_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  phter_pkg::status_type stat,
   output phter_pkg::cmd_type    cmd
);

   phter_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= phter_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         phter_pkg::ST_IDLE:
            if (start) state_in = phter_pkg::ST_SEARCH;
         phter_pkg::ST_SEARCH: begin
            if (stat.key_zero) state_in = phter_pkg::ST_IDLE;
            else if (stat.search_done)
               state_in = stat.found ? phter_pkg::ST_UPDATE : phter_pkg::ST_IDLE;
         end
         phter_pkg::ST_UPDATE:
            state_in = (stat.n_events != 2'd0) ? phter_pkg::ST_EMIT0 : phter_pkg::ST_IDLE;
         phter_pkg::ST_EMIT0:
            state_in = (stat.n_events == 2'd2) ? phter_pkg::ST_EMIT1 : phter_pkg::ST_IDLE;
         phter_pkg::ST_EMIT1:
            state_in = phter_pkg::ST_IDLE;
         default:
            state_in = phter_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         phter_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         phter_pkg::ST_SEARCH: cmd.search = 1'b1;
         phter_pkg::ST_UPDATE: cmd.update = 1'b1;
         phter_pkg::ST_EMIT0:  cmd.emit0  = 1'b1;
         phter_pkg::ST_EMIT1:  cmd.emit1  = 1'b1;
         default:              cmd        = '0;
      endcase
   end

endmodule

>>> rtl/core/phter_datapath.sv
// ----------------------------------------------------------------------------
// phter_datapath: point table, episode bookkeeping and event ring
// Searches one entry per cycle, then does one read-modify-write.
// ----------------------------------------------------------------------------
module phter_datapath #(
   parameter int POINT_SLOTS = phter_pkg::POINT_SLOTS_DEF,
   parameter int RING_DEPTH  = phter_pkg::RING_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  phter_pkg::cmd_type    cmd,
   output phter_pkg::status_type stat,
   input  logic [31:0]           req_point_key,
   input  logic                  req_link_ok,
   input  logic [1:0]            req_alarm_kind,
   input  logic [31:0]           req_value_bits,
   input  logic [31:0]           req_limit_bits,
   input  logic [1:0]            req_compare_code,
   input  logic [31:0]           req_now_ms,
   output logic                  rsp_valid,
   output logic [5:0]            rsp_ring_slot,
   output logic [31:0]           rsp_event_point,
   output logic                  rsp_event_raise,
   output logic                  rsp_event_is_threshold,
   output logic [31:0]           rsp_event_value,
   output logic [31:0]           rsp_event_limit,
   output logic [1:0]            rsp_event_compare,
   output logic [1:0]            rsp_event_reason,
   output logic [31:0]           rsp_event_time_ms,
   output logic                  rsp_last_event
);

   localparam int SW = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
   localparam int CW = $clog2(POINT_SLOTS + 1);
   localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int NW = $clog2(RING_DEPTH + 1);

   // sample registers
   logic [31:0] key_ff, value_ff, limit_ff, now_ff;
   logic        ok_ff;
   logic [1:0]  kind_ff, cmp_ff;

   // point table
   logic [POINT_SLOTS-1:0] used_ff;
   logic [31:0] tkey_ff    [POINT_SLOTS];
   logic        online_ff  [POINT_SLOTS];
   logic [1:0]  akind_ff   [POINT_SLOTS];
   logic [31:0] first_ff   [POINT_SLOTS];
   logic [31:0] last_ff    [POINT_SLOTS];
   logic [31:0] total_ff   [POINT_SLOTS];
   logic [31:0] onsince_ff [POINT_SLOTS];
   logic [31:0] offsince_ff[POINT_SLOTS];

   // search
   logic [CW-1:0] idx_ff;
   logic [SW-1:0] sel_ff, fre_ff;
   logic          fre_ok_ff, new_ff;

   // ring
   logic [63:0]   ring_mem [RING_DEPTH];
   logic [RW-1:0] wpos_ff;
   logic [NW-1:0] count_ff;

   // events of this sample
   logic [1:0] nev_ff, nev_in;
   logic [1:0] r0_ff, r1_ff;

   logic [SW-1:0] cur;
   logic          cur_used, cur_match, last_idx;
   assign cur       = idx_ff[SW-1:0];
   assign cur_used  = used_ff[cur];
   assign cur_match = cur_used && (tkey_ff[cur] == key_ff);
   assign last_idx  = (idx_ff == CW'(POINT_SLOTS - 1));

   assign stat.key_zero    = (key_ff == 32'd0);
   assign stat.search_done = cur_match || last_idx;
   assign stat.found       = cur_match || fre_ok_ff || !cur_used;

   // entry selected for update; a new key reads as cleared
   logic        e_on;
   logic [1:0]  e_kind;
   logic [31:0] e_first, e_total, e_onsince, e_offsince;
   always_comb begin
      e_on       = new_ff ? 1'b0  : online_ff[sel_ff];
      e_kind     = new_ff ? 2'd0  : akind_ff[sel_ff];
      e_first    = new_ff ? 32'd0 : first_ff[sel_ff];
      e_total    = new_ff ? 32'd0 : total_ff[sel_ff];
      e_onsince  = new_ff ? 32'd0 : onsince_ff[sel_ff];
      e_offsince = new_ff ? 32'd0 : offsince_ff[sel_ff];
   end

   logic        ev_a, ev_b, thr_ev;
   logic [1:0]  ra, rb;
   logic [31:0] n_total, n_onsince, n_offsince, n_first;
   logic        accum;
   always_comb begin
      accum      = e_on && (e_onsince != 32'd0) && (now_ff >= e_onsince);
      n_total    = accum ? e_total + (now_ff - e_onsince) : e_total;
      n_first    = (ok_ff && e_first == 32'd0) ? now_ff : e_first;
      ev_a       = 1'b0;
      ra         = phter_pkg::REASON_ONLINE;
      n_onsince  = e_onsince;
      n_offsince = e_offsince;
      if (ok_ff) begin
         if (!e_on) begin
            ev_a       = (e_offsince != 32'd0);
            n_offsince = 32'd0;
            n_onsince  = now_ff;
         end else if (accum) begin
            n_onsince = now_ff;
         end
      end else begin
         n_onsince = 32'd0;
         if (e_on || e_offsince == 32'd0) n_offsince = now_ff;
         ev_a = e_on;
         ra   = phter_pkg::REASON_OFFLINE;
      end
      thr_ev = (kind_ff == phter_pkg::KIND_THRESHOLD) != (e_kind == phter_pkg::KIND_THRESHOLD);
      rb     = (kind_ff == phter_pkg::KIND_THRESHOLD) ? phter_pkg::REASON_THR_RAISE
                                                      : phter_pkg::REASON_THR_CLEAR;
      ev_b   = thr_ev;
   end

   // the update cycle decides on the fresh count, later cycles on the held one
   assign nev_in        = {1'b0, ev_a} + {1'b0, ev_b};
   assign stat.n_events = cmd.update ? nev_in : nev_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= req_point_key;
         ok_ff    <= req_link_ok;
         kind_ff  <= req_alarm_kind;
         value_ff <= req_value_bits;
         limit_ff <= req_limit_bits;
         cmp_ff   <= req_compare_code;
         now_ff   <= req_now_ms;
      end
   end

   // search: one entry a cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff    <= '0;
         fre_ok_ff <= 1'b0;
      end else if (cmd.search) begin
         idx_ff <= idx_ff + CW'(1);
         if (!cur_used && !fre_ok_ff) begin
            fre_ok_ff <= 1'b1;
            fre_ff    <= cur;
         end
         if (stat.search_done) begin
            if (cur_match) begin
               sel_ff <= cur;
               new_ff <= 1'b0;
            end else begin
               sel_ff <= fre_ok_ff ? fre_ff : cur;
               new_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.update) begin
         used_ff[sel_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         tkey_ff[sel_ff]     <= key_ff;
         online_ff[sel_ff]   <= ok_ff;
         akind_ff[sel_ff]    <= kind_ff;
         first_ff[sel_ff]    <= n_first;
         last_ff[sel_ff]     <= ok_ff ? now_ff : (new_ff ? 32'd0 : last_ff[sel_ff]);
         total_ff[sel_ff]    <= n_total;
         onsince_ff[sel_ff]  <= n_onsince;
         offsince_ff[sel_ff] <= n_offsince;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nev_ff <= 2'd0;
      end else if (cmd.update) begin
         nev_ff <= nev_in;
         r0_ff  <= ev_a ? ra : rb;
         r1_ff  <= rb;
      end
   end

   logic       emit;
   logic [1:0] reason;
   logic       thr;
   assign emit   = cmd.emit0 || cmd.emit1;
   assign reason = cmd.emit1 ? r1_ff : r0_ff;
   assign thr    = reason[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff  <= '0;
         count_ff <= '0;
      end else if (emit) begin
         wpos_ff <= (wpos_ff == RW'(RING_DEPTH - 1)) ? '0 : wpos_ff + RW'(1);
         if (count_ff != NW'(RING_DEPTH)) count_ff <= count_ff + NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (emit) ring_mem[wpos_ff] <= {28'd0, cmp_ff, reason, key_ff};
   end

   assign rsp_valid              = emit;
   assign rsp_ring_slot          = 6'(wpos_ff);
   assign rsp_event_point        = key_ff;
   assign rsp_event_raise        = (reason == phter_pkg::REASON_OFFLINE) ||
                                   (reason == phter_pkg::REASON_THR_RAISE);
   assign rsp_event_is_threshold = thr;
   assign rsp_event_value        = value_ff;
   assign rsp_event_limit        = thr ? limit_ff : 32'd0;
   assign rsp_event_compare      = cmp_ff;
   assign rsp_event_reason       = reason;
   assign rsp_event_time_ms      = now_ff;
   assign rsp_last_event         = cmd.emit1 || (nev_ff == 2'd1);

endmodule

>>> rtl/core/point_health_tracker_event_ring_core.sv
// ----------------------------------------------------------------------------
// point_health_tracker_event_ring_core: point health tracker top level
// Per sample: load, a table search of one entry per cycle (up to POINT_SLOTS
// entries), then the update; up to two events follow, one after the other.
// busy is high while a sample is in work; start is only taken while idle.
// A zero key, or a sample with no match and no free entry, yields no events.
// Results are single-cycle strobes; the receiver cannot stall.
// Synchronous reset clears the table valid bits and ring pointer.
// ----------------------------------------------------------------------------
module point_health_tracker_event_ring_core #(
   parameter int POINT_SLOTS = phter_pkg::POINT_SLOTS_DEF,
   parameter int RING_DEPTH  = phter_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_point_key,
   input  logic        req_link_ok,
   input  logic [1:0]  req_alarm_kind,
   input  logic [31:0] req_value_bits,
   input  logic [31:0] req_limit_bits,
   input  logic [1:0]  req_compare_code,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic [5:0]  rsp_ring_slot,
   output logic [31:0] rsp_event_point,
   output logic        rsp_event_raise,
   output logic        rsp_event_is_threshold,
   output logic [31:0] rsp_event_value,
   output logic [31:0] rsp_event_limit,
   output logic [1:0]  rsp_event_compare,
   output logic [1:0]  rsp_event_reason,
   output logic [31:0] rsp_event_time_ms,
   output logic        rsp_last_event
);

   phter_pkg::cmd_type    cmd;
   phter_pkg::status_type stat;

   phter_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   phter_datapath #(
      .POINT_SLOTS (POINT_SLOTS),
      .RING_DEPTH  (RING_DEPTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_point_key          (req_point_key),
      .req_link_ok            (req_link_ok),
      .req_alarm_kind         (req_alarm_kind),
      .req_value_bits         (req_value_bits),
      .req_limit_bits         (req_limit_bits),
      .req_compare_code       (req_compare_code),
      .req_now_ms             (req_now_ms),
      .rsp_valid              (rsp_valid),
      .rsp_ring_slot          (rsp_ring_slot),
      .rsp_event_point        (rsp_event_point),
      .rsp_event_raise        (rsp_event_raise),
      .rsp_event_is_threshold (rsp_event_is_threshold),
      .rsp_event_value        (rsp_event_value),
      .rsp_event_limit        (rsp_event_limit),
      .rsp_event_compare      (rsp_event_compare),
      .rsp_event_reason       (rsp_event_reason),
      .rsp_event_time_ms      (rsp_event_time_ms),
      .rsp_last_event         (rsp_last_event)
   );

endmodule
